FILE: rtl/ucs_pkg.sv
// Shared types and constants for the URL component splitter.
// No dependencies; used by ucs_parser, ucs_result_q and url_component_splitter.
package ucs_pkg;

	localparam int MAX_LEN_DEF = 4096;
	localparam int RQ_DEPTH    = 4;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'd0,
		PH_COLON  = 3'd1,
		PH_SLASH2 = 3'd2,
		PH_DOMAIN = 3'd3,
		PH_PORT   = 3'd4,
		PH_PATH   = 3'd5,
		PH_PARAMS = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		K_PROTO  = 3'd0,
		K_DOMAIN = 3'd1,
		K_PORT   = 3'd2,
		K_PATH   = 3'd3,
		K_PARAMS = 3'd4,
		K_NONE   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_SLASH = 3'd1,
		ST_BAD_PORT  = 3'd2,
		ST_NO_DELIM  = 3'd3,
		ST_END_COLON = 3'd4,
		ST_TOO_LONG  = 3'd5
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [11:0] start;
		logic [12:0] len;
		status_t     status;
		logic        done;
	} result_t;

	// up to two result words produced by one input byte, r0 first
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic [$clog2(RQ_DEPTH+1)-1:0] count;
		logic                          room2;
	} rq_stat_t;

endpackage

FILE: rtl/url_component_splitter.sv
// Top level of the URL component splitter: input register, parser, result queue.
// Depends on ucs_pkg, ucs_parser and ucs_result_q.
//
// Usage:
//  - Input channel (in_valid/in_ready, ch, last): one URL byte per word, last
//    set on the final byte of each URL. URLs follow each other with no gap.
//  - Output channel (out_valid/out_ready, field_kind, start_res, length,
//    status, url_done): one word per closed component, in URL order. An error
//    gives a single word with field_kind none, its status and url_done set;
//    later bytes of that URL give nothing.
//  - Path: a byte is held in the input register until the parser steps on it;
//    that step writes its result words into the queue that drives the output.
//  - Throughput: one byte per cycle while the queue has room for two words. A
//    byte may close two components and the output port moves one word a cycle,
//    so runs of such bytes are held to the queue draining one word per cycle.
//  - Stall: when out_ready is low the four-word result queue fills; the parser
//    steps only while two free slots remain, and in_ready drops once the input
//    register is held.
//  - Reset: arst_n clears the parse state, the input register and the queue;
//    the block is ready for the first byte in the cycle after release.
module url_component_splitter #(
	parameter int MAX_LEN = ucs_pkg::MAX_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  field_kind,
	output logic [11:0] start_res,
	output logic [12:0] length,
	output logic [2:0]  status,
	output logic        url_done
);

	// input register stage
	logic       v_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	logic               advance;
	logic               dropping;
	ucs_pkg::push_t     push;
	ucs_pkg::result_t   head;
	ucs_pkg::rq_stat_t  rq_stat;

	// parser may step only when the queue can take the worst case of two words
	assign advance  = v_s1 && rq_stat.room2;
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	ucs_parser #(
		.MAX_LEN(MAX_LEN)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.ch      (ch_s1),
		.last    (last_s1),
		.push    (push),
		.dropping(dropping)
	);

	ucs_result_q u_rq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.pop     (out_ready),
		.head    (head),
		.nonempty(out_valid),
		.stat    (rq_stat)
	);

	assign field_kind = head.kind;
	assign start_res  = head.start;
	assign length     = head.len;
	assign status     = head.status;
	assign url_done   = head.done;

	// queue never holds more words than it has slots
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_stat.count <= ($clog2(ucs_pkg::RQ_DEPTH + 1))'(ucs_pkg::RQ_DEPTH))
		else $error("result queue overflow");

	// a URL being dropped after an error produces no further words
	a_drop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		advance && dropping |-> push.n == 2'd0)
		else $error("result pushed while dropping");

	// a status-only word always ends its URL with a nonzero status
	a_none_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_kind == ucs_pkg::K_NONE |->
		url_done && status != ucs_pkg::ST_OK && length == 13'd0)
		else $error("malformed status-only word");

	// the parser steps only when the queue has room for two words
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> rq_stat.room2)
		else $error("push without room");

endmodule

FILE: rtl/ucs_parser.sv
// Parse state registers and the per-byte phase logic of the URL splitter.
// Depends on ucs_pkg (phase, kind, status codes, result and push structs).
module ucs_parser #(
	parameter int MAX_LEN = ucs_pkg::MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        ch,
	input  logic              last,
	output ucs_pkg::push_t    push,
	output logic              dropping
);

	localparam int OW = $clog2(MAX_LEN + 1);

	ucs_pkg::phase_t ph_q, ph_d;
	logic [OW-1:0] off_q, off_d, ps_q, ps_d, fse_q, fse_d;
	logic drop_q, drop_d;

	logic digit, em, fail;
	ucs_pkg::status_t fcode;
	ucs_pkg::result_t em_r, fin_r;
	ucs_pkg::kind_t fin_kind;

	function automatic ucs_pkg::result_t mk(ucs_pkg::kind_t k, logic [OW-1:0] s,
			logic [OW-1:0] l, ucs_pkg::status_t st, logic d);
		ucs_pkg::result_t r;
		r.kind   = k;
		r.start  = 12'(s);
		r.len    = 13'(l);
		r.status = st;
		r.done   = d;
		return r;
	endfunction

	always_comb begin
		ph_d     = ph_q;
		off_d    = off_q;
		ps_d     = ps_q;
		fse_d    = fse_q;
		drop_d   = drop_q;
		em       = 1'b0;
		em_r     = mk(ucs_pkg::K_NONE, '0, '0, ucs_pkg::ST_OK, 1'b0);
		fail     = 1'b0;
		fcode    = ucs_pkg::ST_OK;
		fin_kind = ucs_pkg::K_PARAMS;
		fin_r    = mk(ucs_pkg::K_NONE, '0, '0, ucs_pkg::ST_OK, 1'b0);
		push     = '0;
		digit    = (ch >= ucs_pkg::CH_ZERO) && (ch <= ucs_pkg::CH_NINE);

		if (drop_q) begin
			if (last) begin
				ph_d   = ucs_pkg::PH_FIRST;
				off_d  = '0;
				ps_d   = '0;
				fse_d  = '0;
				drop_d = 1'b0;
			end
		end else begin
			if (off_q >= OW'(MAX_LEN)) begin
				fail  = 1'b1;
				fcode = ucs_pkg::ST_TOO_LONG;
			end else begin
				unique case (ph_q)
					ucs_pkg::PH_FIRST: begin
						if (ch == ucs_pkg::CH_COLON) begin
							fse_d = off_q;
							ph_d  = ucs_pkg::PH_COLON;
						end else if (ch == ucs_pkg::CH_SLASH) begin
							em   = 1'b1;
							em_r = mk(ucs_pkg::K_DOMAIN, '0, off_q, ucs_pkg::ST_OK, 1'b0);
							ps_d = off_q + 1'b1;
							ph_d = ucs_pkg::PH_PATH;
						end
					end
					ucs_pkg::PH_COLON: begin
						if (ch == ucs_pkg::CH_SLASH) begin
							ph_d = ucs_pkg::PH_SLASH2;
						end else if (ch == ucs_pkg::CH_QMARK) begin
							em   = 1'b1;
							em_r = mk(ucs_pkg::K_DOMAIN, '0, fse_q, ucs_pkg::ST_OK, 1'b0);
							ps_d = off_q + 1'b1;
							ph_d = ucs_pkg::PH_PARAMS;
						end else if (digit) begin
							em   = 1'b1;
							em_r = mk(ucs_pkg::K_DOMAIN, '0, fse_q, ucs_pkg::ST_OK, 1'b0);
							ps_d = off_q;
							ph_d = ucs_pkg::PH_PORT;
						end else begin
							fail  = 1'b1;
							fcode = ucs_pkg::ST_BAD_PORT;
						end
					end
					ucs_pkg::PH_SLASH2: begin
						if (ch != ucs_pkg::CH_SLASH) begin
							fail  = 1'b1;
							fcode = ucs_pkg::ST_BAD_SLASH;
						end else begin
							em   = 1'b1;
							em_r = mk(ucs_pkg::K_PROTO, '0, fse_q, ucs_pkg::ST_OK, 1'b0);
							ps_d = off_q + 1'b1;
							ph_d = ucs_pkg::PH_DOMAIN;
						end
					end
					ucs_pkg::PH_DOMAIN: begin
						if (ch == ucs_pkg::CH_COLON || ch == ucs_pkg::CH_SLASH) begin
							em   = 1'b1;
							em_r = mk(ucs_pkg::K_DOMAIN, ps_q, off_q - ps_q,
								ucs_pkg::ST_OK, 1'b0);
							ps_d = off_q + 1'b1;
							ph_d = (ch == ucs_pkg::CH_COLON) ? ucs_pkg::PH_PORT
								: ucs_pkg::PH_PATH;
						end
					end
					ucs_pkg::PH_PORT: begin
						if (ch == ucs_pkg::CH_SLASH || ch == ucs_pkg::CH_QMARK) begin
							em   = 1'b1;
							em_r = mk(ucs_pkg::K_PORT, ps_q, off_q - ps_q,
								ucs_pkg::ST_OK, 1'b0);
							ps_d = off_q + 1'b1;
							ph_d = (ch == ucs_pkg::CH_SLASH) ? ucs_pkg::PH_PATH
								: ucs_pkg::PH_PARAMS;
						end else if (!digit) begin
							fail  = 1'b1;
							fcode = ucs_pkg::ST_BAD_PORT;
						end
					end
					ucs_pkg::PH_PATH: begin
						if (ch == ucs_pkg::CH_QMARK) begin
							em   = 1'b1;
							em_r = mk(ucs_pkg::K_PATH, ps_q, off_q - ps_q,
								ucs_pkg::ST_OK, 1'b0);
							ps_d = off_q + 1'b1;
							ph_d = ucs_pkg::PH_PARAMS;
						end
					end
					ucs_pkg::PH_PARAMS: begin
					end
					default: ph_d = ucs_pkg::PH_PARAMS;
				endcase
			end

			// end-of-URL checks; an open first segment, colon or slash pair is an error
			if (!fail && last) begin
				case (ph_d)
					ucs_pkg::PH_FIRST: begin
						fail  = 1'b1;
						fcode = ucs_pkg::ST_NO_DELIM;
					end
					ucs_pkg::PH_COLON: begin
						fail  = 1'b1;
						fcode = ucs_pkg::ST_END_COLON;
					end
					ucs_pkg::PH_SLASH2: begin
						fail  = 1'b1;
						fcode = ucs_pkg::ST_BAD_SLASH;
					end
					ucs_pkg::PH_DOMAIN: fin_kind = ucs_pkg::K_DOMAIN;
					ucs_pkg::PH_PORT:   fin_kind = ucs_pkg::K_PORT;
					ucs_pkg::PH_PATH:   fin_kind = ucs_pkg::K_PATH;
					default:            fin_kind = ucs_pkg::K_PARAMS;
				endcase
			end

			if (fail) begin
				push.n  = 2'd1;
				push.r0 = mk(ucs_pkg::K_NONE, '0, '0, fcode, 1'b1);
				ph_d    = ucs_pkg::PH_FIRST;
				off_d   = '0;
				ps_d    = '0;
				fse_d   = '0;
				drop_d  = !last;
			end else if (last) begin
				fin_r   = mk(fin_kind, ps_d, off_q + 1'b1 - ps_d, ucs_pkg::ST_OK, 1'b1);
				push.n  = em ? 2'd2 : 2'd1;
				push.r0 = em ? em_r : fin_r;
				push.r1 = fin_r;
				ph_d    = ucs_pkg::PH_FIRST;
				off_d   = '0;
				ps_d    = '0;
				fse_d   = '0;
			end else begin
				push.n  = em ? 2'd1 : 2'd0;
				push.r0 = em_r;
				off_d   = off_q + 1'b1;
			end
		end

		if (!step) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= ucs_pkg::PH_FIRST;
			off_q  <= '0;
			ps_q   <= '0;
			fse_q  <= '0;
			drop_q <= 1'b0;
		end else if (step) begin
			ph_q   <= ph_d;
			off_q  <= off_d;
			ps_q   <= ps_d;
			fse_q  <= fse_d;
			drop_q <= drop_d;
		end
	end

	assign dropping = drop_q;

endmodule

FILE: rtl/ucs_result_q.sv
// Result queue: takes up to two result words per cycle, hands out one.
// Depends on ucs_pkg (result_t, push_t, rq_stat_t, RQ_DEPTH).
module ucs_result_q (
	input  logic               clk,
	input  logic               arst_n,
	input  ucs_pkg::push_t     push,
	input  logic               pop,
	output ucs_pkg::result_t   head,
	output logic               nonempty,
	output ucs_pkg::rq_stat_t  stat
);

	localparam int D  = ucs_pkg::RQ_DEPTH;
	localparam int PW = $clog2(D);
	localparam int CW = $clog2(D + 1);

	ucs_pkg::result_t mem_q [D];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_pop;

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wp_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(push.n);
			rp_q  <= rp_q + PW'(do_pop);
			cnt_q <= cnt_q + CW'(push.n) - CW'(do_pop);
		end
	end

	assign head       = mem_q[rp_q];
	assign nonempty   = (cnt_q != '0);
	assign stat.count = cnt_q;
	assign stat.room2 = (cnt_q <= CW'(D - 2));

endmodule
